[hw/rtl/cft_pkg.sv]
package cft_pkg;

   // Depth of the word queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 4;

   // One input word yields at most this many results.
   localparam int unsigned RES_MAX = 3;

   // Result kinds.
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_DISCARD = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;

   // Register file: one register, word index in paddr[2].
   localparam int unsigned CSR_ADDR_W          = 3;
   localparam logic        REG_FIELD_SEPARATOR = 1'b0;
   localparam logic [7:0]  SEPARATOR_RESET     = 8'd44;

   // Parser state carried from byte to byte.
   typedef struct packed {
      logic inside_quotes;
      logic quote_waiting;
      logic field_only_padding;
   } cft_state_type;

   localparam cft_state_type STATE_RESET = '{
      inside_quotes: 1'b0, quote_waiting: 1'b0, field_only_padding: 1'b1};

   // One result as it leaves the block, without the last-of-run flag.
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       line_end;
   } cft_result_type;

   // All results caused by one input word, packed from index 0 upward.
   typedef struct packed {
      cft_result_type [RES_MAX-1:0] res;
      logic [1:0]                   count;
   } cft_bundle_type;

   // Outcome of feeding one byte to the parser.
   typedef struct packed {
      cft_state_type  st;
      logic           emit;
      cft_result_type res;
   } cft_step_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic empty;
      logic full;
   } cft_qstat_type;

   function automatic logic is_pad(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
             (c == CH_VT) || (c == CH_FF);
   endfunction

   // Feed one byte to the parser and return the new state and any result.
   function automatic cft_step_type take_byte(cft_state_type s, logic [7:0] c,
                                              logic [7:0] sep);
      cft_step_type r;
      logic         inq;
      r      = '0;
      r.st   = s;
      inq    = s.inside_quotes && !s.quote_waiting;
      if (s.quote_waiting && (c == CH_QUOTE)) begin
         // Doubled quote inside a quoted field gives a literal quote.
         r.st.quote_waiting      = 1'b0;
         r.emit                  = 1'b1;
         r.res.data              = CH_QUOTE;
         r.res.kind              = KIND_BYTE;
         r.st.field_only_padding = 1'b0;
      end else begin
         // A waiting quote that is not doubled closes the quoted part.
         r.st.quote_waiting = 1'b0;
         r.st.inside_quotes = inq;
         if (inq) begin
            if (c == CH_QUOTE) begin
               r.st.quote_waiting = 1'b1;
            end else begin
               r.emit                  = 1'b1;
               r.res.data              = c;
               r.res.kind              = KIND_BYTE;
               r.st.field_only_padding = s.field_only_padding && is_pad(c);
            end
         end else if ((c == CH_QUOTE) && s.field_only_padding) begin
            r.emit                  = 1'b1;
            r.res.kind              = KIND_DISCARD;
            r.st.inside_quotes      = 1'b1;
            r.st.field_only_padding = 1'b1;
         end else if (c == sep) begin
            r.emit                  = 1'b1;
            r.res.kind              = KIND_END;
            r.st.field_only_padding = 1'b1;
         end else begin
            r.emit                  = 1'b1;
            r.res.data              = c;
            r.res.kind              = KIND_BYTE;
            r.st.field_only_padding = s.field_only_padding && is_pad(c);
         end
      end
      return r;
   endfunction

endpackage

[hw/rtl/cft_front.sv]
module cft_front
   import cft_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     sep,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_in_byte,
   input  logic           req_ends_line,
   input  logic           req_byte_absent,
   input  cft_qstat_type  qstat,
   output logic           push,
   output cft_bundle_type bundle
);

   cft_state_type state_ff, state_in;
   logic          rw_ff, rw_in;
   cft_step_type  step_cr, step_b;
   logic [1:0]    cnt;
   logic          accept;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (bundle.count != 2'd0);

   // Classify the word: a held return first, then the byte, then the line end.
   always_comb begin
      state_in = state_ff;
      rw_in    = rw_ff;
      bundle   = '0;
      cnt      = 2'd0;
      step_cr  = take_byte(state_ff, CH_CR, sep);
      step_b   = '0;
      if (!req_byte_absent) begin
         if (rw_ff) begin
            state_in = step_cr.st;
            rw_in    = 1'b0;
            if (step_cr.emit) begin
               bundle.res[cnt] = step_cr.res;
               cnt             = cnt + 2'd1;
            end
         end
         step_b = take_byte(state_in, req_in_byte, sep);
         if (req_in_byte == CH_CR) begin
            // Hold the return; a waiting quote closes before it.
            if (state_in.quote_waiting) begin
               state_in.quote_waiting = 1'b0;
               state_in.inside_quotes = 1'b0;
            end
            rw_in = 1'b1;
         end else begin
            state_in = step_b.st;
            if (step_b.emit) begin
               bundle.res[cnt] = step_b.res;
               cnt             = cnt + 2'd1;
            end
         end
      end
      if (req_ends_line) begin
         // Close the last field; a held return is dropped.
         rw_in                    = 1'b0;
         state_in                 = STATE_RESET;
         bundle.res[cnt].data     = 8'd0;
         bundle.res[cnt].kind     = KIND_END;
         bundle.res[cnt].line_end = 1'b1;
         cnt                      = cnt + 2'd1;
      end
      bundle.count = cnt;
   end

   // Parser state advances on every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         rw_ff    <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
         rw_ff    <= rw_in;
      end
   end

endmodule

[hw/rtl/cft_queue.sv]
module cft_queue
   import cft_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cft_bundle_type wr_data,
   input  logic           pop,
   output cft_bundle_type head,
   output cft_qstat_type  qstat
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cft_bundle_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign qstat.empty = (fill_ff == '0);
   assign qstat.full  = (fill_ff == CNT_W'(DEPTH));
   assign head        = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping; pointers wrap at the last entry.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_ff + PTR_W'(1));
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_ff + PTR_W'(1));
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (!push && pop) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hw/rtl/cft_back.sv]
module cft_back
   import cft_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cft_bundle_type head,
   input  cft_qstat_type  qstat,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [7:0]     rsp_out_byte,
   output logic [1:0]     rsp_kind,
   output logic           rsp_line_end,
   output logic           rsp_last_of_run
);

   logic [1:0]     idx_ff, idx_in;
   cft_result_type cur;
   logic           last;
   logic           take;

   // Walk the results of the head word one per cycle while rsp_ready is high.
   assign cur             = head.res[idx_ff];
   assign last            = (idx_ff == (head.count - 2'd1));
   assign rsp_valid       = !qstat.empty;
   assign rsp_out_byte    = cur.data;
   assign rsp_kind        = cur.kind;
   assign rsp_line_end    = cur.line_end;
   assign rsp_last_of_run = last;
   assign take            = rsp_valid && rsp_ready;
   assign pop             = take && last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last ? 2'd0 : (idx_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[hw/rtl/csv_field_tokenizer.sv]
// Streaming CSV line splitter. The req channel takes one word per cycle
// while the queue is not full: a byte of the line, a flag that the word
// ends the line, and a flag that the byte is absent. The rsp channel gives
// field bytes, end-of-field and discard markers, one result per cycle while
// rsp_ready is high; the last result a word causes carries rsp_last_of_run,
// and the end of field that closes the line carries rsp_line_end. A word
// gives zero to three results, which are registered in the queue and then
// offered in order behind earlier words. Since the output gives one result
// per cycle, words with several results set the sustained rate. A queue of
// DEPTH words (QUEUE_DEPTH by default) sits between the parser and the
// output, so a stalled receiver holds req_ready high until the queue fills.
// The separator register sits at byte address 0 on the csr port and reads
// back; write it only while the block is idle.
// Synchronous reset empties the queue, clears the parser state and sets the
// separator to a comma.
module csv_field_tokenizer
   import cft_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_ends_line,
   input  logic                  req_byte_absent,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic [1:0]            rsp_kind,
   output logic                  rsp_line_end,
   output logic                  rsp_last_of_run,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [7:0]     sep_ff;
   logic           csr_wr;
   logic           push;
   logic           pop;
   cft_bundle_type bundle;
   cft_bundle_type head;
   cft_qstat_type  qstat;

   // Register access.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_FIELD_SEPARATOR);
   assign csr_prdata = (csr_paddr[2] == REG_FIELD_SEPARATOR) ?
                       {24'd0, sep_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= SEPARATOR_RESET;
      end else if (csr_wr) begin
         sep_ff <= csr_pwdata[7:0];
      end
   end

   cft_front u_front (
      .clock           (clock),
      .reset           (reset),
      .sep             (sep_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_ends_line   (req_ends_line),
      .req_byte_absent (req_byte_absent),
      .qstat           (qstat),
      .push            (push),
      .bundle          (bundle)
   );

   cft_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (bundle),
      .pop     (pop),
      .head    (head),
      .qstat   (qstat)
   );

   cft_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_kind        (rsp_kind),
      .rsp_line_end    (rsp_line_end),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // The queue never takes a word while full.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full))
      else $error("word pushed into a full queue");

   // A line end is always the final end-of-field of its word.
   a_line_end_kind : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_end) |-> ((rsp_kind == KIND_END) && rsp_last_of_run))
      else $error("line end on a result that is not the closing end of field");

   // Markers carry a zero byte.
   a_marker_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_BYTE)) |-> (rsp_out_byte == 8'd0))
      else $error("marker result with nonzero byte");

   // Nothing is offered right after reset.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   import cft_pkg::*;

   // One result as the receiver sees it.
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       line_end;
      logic       last;
   } csv_token_type;

   // Tracks the tokenizer state, predicts the results of every accepted word
   // and matches them against the results that come out.
   class token_scoreboard;
      bit [7:0]      separator;
      bit            quoted_field;
      bit            quote_held;
      bit            return_held;
      bit            only_padding;
      csv_token_type tokens_due[$];
      csv_token_type run_buf[RES_MAX];
      int            run_len;
      int unsigned   mismatches;
      int unsigned   tokens_checked;
      int unsigned   lines_closed;

      function new();
         separator = SEPARATOR_RESET;
         clear_line();
      endfunction

      function void clear_line();
         quoted_field = 1'b0;
         quote_held   = 1'b0;
         return_held  = 1'b0;
         only_padding = 1'b1;
      endfunction

      function bit is_padding(bit [7:0] c);
         return c inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
      endfunction

      function void add_token(bit [7:0] d, bit [1:0] k, bit le);
         if (run_len < RES_MAX) begin
            run_buf[run_len] = '{data: d, kind: k, line_end: le, last: 1'b0};
            run_len++;
         end
      endfunction

      // One byte through the field splitter.
      function void take_char(bit [7:0] c);
         if (quote_held) begin
            quote_held = 1'b0;
            // Two quotes in a row inside a quoted field give one literal quote.
            if (c == CH_QUOTE) begin
               add_token(CH_QUOTE, KIND_BYTE, 1'b0);
               only_padding = 1'b0;
               return;
            end
            quoted_field = 1'b0;
         end
         if (quoted_field) begin
            if (c == CH_QUOTE) begin
               quote_held = 1'b1;
            end else begin
               add_token(c, KIND_BYTE, 1'b0);
               only_padding = only_padding && is_padding(c);
            end
         end else if (c == CH_QUOTE && only_padding) begin
            add_token(8'h00, KIND_DISCARD, 1'b0);
            quoted_field = 1'b1;
            only_padding = 1'b1;
         end else if (c == separator) begin
            add_token(8'h00, KIND_END, 1'b0);
            only_padding = 1'b1;
         end else begin
            add_token(c, KIND_BYTE, 1'b0);
            only_padding = only_padding && is_padding(c);
         end
      endfunction

      // Called for every word the block accepts.
      function void note_word(bit [7:0] b, bit ends, bit absent);
         run_len = 0;
         if (!absent) begin
            // A held carriage return was not the last byte, so it counts now.
            if (return_held) begin
               return_held = 1'b0;
               take_char(CH_CR);
            end
            if (b == CH_CR) begin
               if (quote_held) begin
                  quote_held   = 1'b0;
                  quoted_field = 1'b0;
               end
               return_held = 1'b1;
            end else begin
               take_char(b);
            end
         end
         if (ends) begin
            add_token(8'h00, KIND_END, 1'b1);
            clear_line();
            lines_closed++;
         end
         for (int i = 0; i < run_len; i++) begin
            if (i == run_len - 1) run_buf[i].last = 1'b1;
            tokens_due.insert(tokens_due.size(), run_buf[i]);
         end
      endfunction

      function void mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", msg);
      endfunction

      function void check_token(csv_token_type got);
         csv_token_type want;
         tokens_checked++;
         if (tokens_due.size() == 0) begin
            mismatch($sformatf("unexpected result data=%h kind=%0d line_end=%b last=%b",
                               got.data, got.kind, got.line_end, got.last));
            return;
         end
         want = tokens_due.pop_front();
         if (got !== want) begin
            mismatch($sformatf({"result %0d: expected data=%h kind=%0d line_end=%b ",
                                "last=%b, got data=%h kind=%0d line_end=%b last=%b"},
                               tokens_checked, want.data, want.kind, want.line_end,
                               want.last, got.data, got.kind, got.line_end, got.last));
         end
      endfunction
   endclass

   localparam logic [CSR_ADDR_W-1:0] SEP_ADDR = {REG_FIELD_SEPARATOR, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_in_byte;
   logic                  req_ends_line;
   logic                  req_byte_absent;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_out_byte;
   logic [1:0]            rsp_kind;
   logic                  rsp_line_end;
   logic                  rsp_last_of_run;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   token_scoreboard sb;
   int unsigned     send_gap_pct   = 6;
   int unsigned     recv_stall_pct = 74;
   int unsigned     words_sent;
   int unsigned     settings_used;
   bit [7:0]        line_buf[$];

   csv_field_tokenizer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_ends_line   (req_ends_line),
      .req_byte_absent (req_byte_absent),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_kind        (rsp_kind),
      .rsp_line_end    (rsp_line_end),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: checks each accepted result and stalls at random.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_token('{data: rsp_out_byte, kind: rsp_kind,
                             line_end: rsp_line_end, last: rsp_last_of_run});
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one word, possibly after idle cycles, and waits for acceptance.
   task automatic send_word(bit [7:0] b, bit ends, bit absent);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_ends_line   <= ends;
      req_byte_absent <= absent;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(b, ends, absent);
      if (!absent || ends) words_sent++;
   endtask

   // Sends a text as one line; the line may be closed by an absent-byte word.
   task automatic send_text(string s, bit end_absent);
      for (int i = 0; i < s.len(); i++) begin
         send_word(s[i], (i == s.len() - 1) && !end_absent, 1'b0);
      end
      if (end_absent) send_word(8'($urandom_range(255)), 1'b1, 1'b1);
   endtask

   // One APB transfer: setup cycle, then access until pready.
   task automatic csr_access(bit wr, bit [31:0] wdata, output bit [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= SEP_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_separator_readback(bit [7:0] want);
      bit [31:0] rd;
      csr_access(1'b0, 32'h0, rd);
      if (rd[7:0] !== want) begin
         sb.mismatch($sformatf("separator reads %h, expected %h", rd[7:0], want));
      end
   endtask

   task automatic set_separator(bit [7:0] v);
      bit [31:0] rd;
      csr_access(1'b1, {24'h0, v}, rd);
      sb.separator = v;
      settings_used++;
      check_separator_readback(v);
   endtask

   // Waits until every predicted result has come, then lets the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.tokens_due.size() != 0) @(posedge clock);
      repeat (QUEUE_DEPTH + 4) @(posedge clock);
   endtask

   function automatic bit [7:0] pad_byte();
      case ($urandom_range(4))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         3:       return CH_VT;
         default: return CH_FF;
      endcase
   endfunction

   function automatic bit [7:0] plain_byte();
      return 8'($urandom_range(8'h7A, 8'h61));
   endfunction

   // Content byte biased toward the bytes that steer the splitter.
   function automatic bit [7:0] any_byte();
      case ($urandom_range(7))
         0:       return sb.separator;
         1:       return CH_QUOTE;
         2:       return CH_CR;
         3:       return pad_byte();
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Appends one byte to the line being built.
   function automatic void add_line_byte(bit [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endfunction

   // Builds a mostly well-formed line of plain, quoted, padded and raw fields.
   function automatic void build_line();
      int nf;
      line_buf.delete();
      nf = $urandom_range(4, 1);
      for (int f = 0; f < nf; f++) begin
         if (f > 0) add_line_byte(sb.separator);
         case ($urandom_range(4))
            0: repeat ($urandom_range(4)) add_line_byte(plain_byte());
            1: begin
               repeat ($urandom_range(2)) add_line_byte(pad_byte());
               add_line_byte(CH_QUOTE);
               repeat ($urandom_range(5)) begin
                  if ($urandom_range(4) == 0) begin
                     add_line_byte(CH_QUOTE);
                     add_line_byte(CH_QUOTE);
                  end else begin
                     add_line_byte(any_byte());
                  end
               end
               if ($urandom_range(3) != 0) add_line_byte(CH_QUOTE);
               repeat ($urandom_range(2)) add_line_byte(any_byte());
            end
            2: repeat ($urandom_range(5, 1)) add_line_byte(any_byte());
            3: repeat ($urandom_range(3, 1)) add_line_byte(pad_byte());
            default: begin
               add_line_byte(plain_byte());
               add_line_byte(CH_QUOTE);
               add_line_byte(plain_byte());
            end
         endcase
      end
      if ($urandom_range(5) == 0) add_line_byte(CH_CR);
   endfunction

   // Sends the built line with occasional absent-byte words mixed in.
   task automatic send_line();
      bit end_absent;
      end_absent = ($urandom_range(5) == 0) || (line_buf.size() == 0);
      foreach (line_buf[i]) begin
         if ($urandom_range(11) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
         send_word(line_buf[i], (i == line_buf.size() - 1) && !end_absent, 1'b0);
      end
      if (end_absent) send_word(8'($urandom_range(255)), 1'b1, 1'b1);
   endtask

   initial begin
      bit [7:0]    sep_plan[9];
      int unsigned target;
      sb = new();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_in_byte     <= 8'h00;
      req_ends_line   <= 1'b0;
      req_byte_absent <= 1'b0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= 32'h0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_separator_readback(SEPARATOR_RESET);
      settings_used = 1;

      // Directed lines with the comma separator from reset.
      send_text("a,b", 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hFF, 1'b1, 1'b0);
      // Empty line, then an ignored absent byte inside a line.
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hA5, 1'b0, 1'b1);
      send_text("x", 1'b0);
      // Padding dropped by an opening quote, doubled quote, bytes after the
      // closing quote, and a held return dropped by an absent-byte line end.
      send_text(" \"x\"\"y\"z\015", 1'b1);
      // Quote never closed, and a quote still waiting at the line end.
      send_text("\"q", 1'b0);
      send_text("\"a\"", 1'b0);
      // A waiting quote closed by a return that later turns into a byte.
      send_text("\"\"\015,k", 1'b0);
      // Return as the last byte, then a quote in the middle of a field.
      send_text("k\015", 1'b0);
      send_text("a\"b", 1'b0);
      drain();

      // Random lines over a sweep of separators and three pacing patterns.
      sep_plan = '{8'h00, 8'hFF, CH_QUOTE, CH_CR, CH_SPACE, 8'h00, 8'd44, CH_TAB, 8'h00};
      sep_plan[5] = 8'($urandom_range(255));
      sep_plan[8] = 8'($urandom_range(255));
      for (int seg = 0; seg < 9; seg++) begin
         if (seg < 3) begin
            send_gap_pct   = 6;
            recv_stall_pct = 74;
         end else if (seg < 6) begin
            send_gap_pct   = 74;
            recv_stall_pct = 6;
         end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         set_separator(sep_plan[seg]);
         target = words_sent + 40;
         while (words_sent < target) begin
            build_line();
            send_line();
         end
         drain();
      end

      $display("Run covered %0d words in %0d lines and checked %0d results,", words_sent,
               sb.lines_closed, sb.tokens_checked);
      $display("over %0d separator settings and three handshake pacing patterns.",
               settings_used);
      if (sb.mismatches == 0 && sb.tokens_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
